[rtl/swsa_pkg.sv]
package swsa_pkg;

  // fixed field widths
  localparam int RD_W      = 8;
  localparam int KQ_W      = 6;
  localparam int FILL_W    = 4;
  localparam int MUL_CNT_W = 6;

  // threshold multiplier after reset: 2.0 in quarters
  localparam logic [KQ_W-1:0] K_QUARTERS_RESET = 6'd8;

  typedef logic [RD_W-1:0]   reading_t;
  typedef logic [KQ_W-1:0]   kq_t;
  typedef logic [FILL_W-1:0] fill_t;

  // sequencer states
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SUM    = 11'b000_0000_0010,
    ST_SQ_OLD = 11'b000_0000_0100,
    ST_SQ_NEW = 11'b000_0000_1000,
    ST_NT     = 11'b000_0001_0000,
    ST_NQ     = 11'b000_0010_0000,
    ST_SS     = 11'b000_0100_0000,
    ST_DD     = 11'b000_1000_0000,
    ST_KK     = 11'b001_0000_0000,
    ST_KS     = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  // multiplier command and status
  typedef struct packed {
    logic                 start;
    logic [MUL_CNT_W-1:0] nbits;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

[rtl/swsa_reading_if.sv]
interface swsa_reading_if;
  logic               valid;
  logic               ready;
  swsa_pkg::reading_t reading;

  modport source (output valid, output reading, input ready);
  modport sink (input valid, input reading, output ready);
endinterface

[rtl/swsa_result_if.sv]
interface swsa_result_if;
  logic            valid;
  logic            ready;
  logic            alert;
  swsa_pkg::fill_t fill_count;

  modport source (output valid, output alert, output fill_count, input ready);
  modport sink (input valid, input alert, input fill_count, output ready);
endinterface

[rtl/swsa_cfg_if.sv]
interface swsa_cfg_if;
  logic          valid;
  logic          ready;
  swsa_pkg::kq_t k_quarters;

  modport source (output valid, output k_quarters, input ready);
  modport sink (input valid, input k_quarters, output ready);
endinterface

[rtl/swsa_ram.sv]
module swsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/swsa_mul.sv]
module swsa_mul #(
  parameter int AW = 24,
  parameter int BW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  swsa_pkg::mul_ctl_t ctl,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output swsa_pkg::mul_sts_t sts,
  output logic [AW+BW-1:0]   prod
);
  import swsa_pkg::*;

  localparam int PW = AW + BW;

  logic [AW-1:0]        mcand;
  logic [BW-1:0]        mplier;
  logic [PW-1:0]        acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  // iteration control, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // msb-first shift-add, multiplier arrives left aligned
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand  <= a;
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      acc    <= {acc[PW-2:0], 1'b0} + (mplier[BW-1] ? PW'(mcand) : PW'(0));
      mplier <= {mplier[BW-2:0], 1'b0};
    end
  end

  assign prod     = acc;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

[rtl/sliding_window_sigma_alert_top.sv]
// rolling mean plus k sigma temperature alert
//
// sample: one 8-bit reading per transfer (valid/ready). the reading enters a
//   ring of the last WINDOW readings; the fill count saturates at WINDOW.
// result: one transfer per reading with alert and fill_count. alert is high
//   when the reading is above mean + (k_quarters/4) * population sigma of the
//   window, new reading included, tested exactly on integers without a root.
// cfg: writes k_quarters; ready is always high. write only while idle.
// sequence: all products run through one bit-serial shift-add multiplier, one
//   multiplier bit per cycle, up to eight products in turn. the square of the
//   evicted reading is skipped while the window is still filling, and the last
//   three products are skipped when the reading is not above the mean. one
//   reading is in work at a time; the next can be taken in the cycle after the
//   result is registered.
// stall: the result sits in an output register; a new reading is taken while
//   it waits, and the block holds before its next result until it is taken.
// reset: sums, fill count and write slot clear, k_quarters returns to 8; the
//   window memory is not cleared, entries are only read after being written.
module sliding_window_sigma_alert_top #(
  parameter int WINDOW = 10
) (
  input logic           clk,
  input logic           rst,
  swsa_reading_if.sink  sample,
  swsa_result_if.source result,
  swsa_cfg_if.sink      cfg
);
  import swsa_pkg::*;

  localparam int NW  = $clog2(WINDOW + 1);
  localparam int SLW = $clog2(WINDOW);
  localparam int SW  = $clog2(WINDOW * 255 + 1);
  localparam int QW  = $clog2(WINDOW * 65025 + 1);
  localparam int SPW = NW + QW;
  localparam int AW  = SPW;
  localparam int BW  = (SW > 2 * KQ_W) ? SW : 2 * KQ_W;
  localparam int PW  = AW + BW;
  localparam int LW  = 2 * SW + 4;
  localparam int RW  = 2 * KQ_W + SPW;
  localparam int CW  = (LW > RW) ? LW : RW;

  state_t          state;
  logic [SLW-1:0]  slot;
  logic [NW-1:0]   filled;
  logic [SW-1:0]   sum;
  logic [SW:0]     sum_next;
  logic [QW-1:0]   sq_sum;
  kq_t             k_quarters;
  logic            res_valid;
  logic            res_alert;
  fill_t           res_fill;
  reading_t        t;
  reading_t        old_rd;
  logic            evict;
  logic            pos;
  logic            alert_q;
  logic [SW-1:0]   diff_mag;
  logic [SPW-1:0]  nq;
  logic [SPW-1:0]  spread;
  logic [LW-1:0]   lhs;
  logic            load_res;
  mul_ctl_t        mul_ctl;
  mul_sts_t        mul_sts;
  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   mul_prod;

  // window store
  swsa_ram #(
    .WIDTH (RD_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_res),
    .wr_addr (slot),
    .wr_data (t),
    .rd_addr (slot),
    .rd_data (old_rd)
  );

  // shared bit-serial multiplier
  swsa_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .sts  (mul_sts),
    .prod (mul_prod)
  );

  // oldest reading leaves, new one enters
  assign sum_next = {1'b0, sum} - (SW + 1)'(evict ? old_rd : reading_t'(0))
                    + (SW + 1)'(t);

  assign load_res = (state == ST_DONE) && (!res_valid || result.ready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_quarters <= K_QUARTERS_RESET;
    end else if (cfg.valid) begin
      k_quarters <= cfg.k_quarters;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      filled        <= '0;
      slot          <= '0;
      sum           <= '0;
      sq_sum        <= '0;
      res_valid     <= 1'b0;
      mul_ctl.start <= 1'b0;
    end else begin
      mul_ctl.start <= 1'b0;
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            t     <= sample.reading;
            evict <= (filled == NW'(WINDOW));
            if (filled != NW'(WINDOW)) begin
              filled <= filled + 1'b1;
            end
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum           <= sum_next[SW-1:0];
          mul_ctl.start <= 1'b1;
          mul_ctl.nbits <= MUL_CNT_W'(RD_W);
          if (evict) begin
            mul_a <= AW'(old_rd);
            mul_b <= BW'(old_rd) << (BW - RD_W);
            state <= ST_SQ_OLD;
          end else begin
            mul_a <= AW'(t);
            mul_b <= BW'(t) << (BW - RD_W);
            state <= ST_SQ_NEW;
          end
        end
        ST_SQ_OLD: begin
          if (mul_sts.done) begin
            sq_sum        <= sq_sum - QW'(mul_prod[2*RD_W-1:0]);
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(RD_W);
            mul_a         <= AW'(t);
            mul_b         <= BW'(t) << (BW - RD_W);
            state         <= ST_SQ_NEW;
          end
        end
        ST_SQ_NEW: begin
          if (mul_sts.done) begin
            sq_sum        <= sq_sum + QW'(mul_prod[2*RD_W-1:0]);
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(NW);
            mul_a         <= AW'(t);
            mul_b         <= BW'(filled) << (BW - NW);
            state         <= ST_NT;
          end
        end
        ST_NT: begin
          if (mul_sts.done) begin
            pos           <= mul_prod[SW-1:0] > sum;
            diff_mag      <= mul_prod[SW-1:0] - sum;
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(NW);
            mul_a         <= AW'(sq_sum);
            mul_b         <= BW'(filled) << (BW - NW);
            state         <= ST_NQ;
          end
        end
        ST_NQ: begin
          if (mul_sts.done) begin
            nq            <= mul_prod[SPW-1:0];
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(SW);
            mul_a         <= AW'(sum);
            mul_b         <= BW'(sum) << (BW - SW);
            state         <= ST_SS;
          end
        end
        ST_SS: begin
          if (mul_sts.done) begin
            // n*Q - S^2 is never negative with exact sums
            spread <= nq - mul_prod[SPW-1:0];
            if (pos) begin
              mul_ctl.start <= 1'b1;
              mul_ctl.nbits <= MUL_CNT_W'(SW);
              mul_a         <= AW'(diff_mag);
              mul_b         <= BW'(diff_mag) << (BW - SW);
              state         <= ST_DD;
            end else begin
              alert_q <= 1'b0;
              state   <= ST_DONE;
            end
          end
        end
        ST_DD: begin
          if (mul_sts.done) begin
            lhs           <= {mul_prod[2*SW-1:0], 4'b0000};
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(KQ_W);
            mul_a         <= AW'(k_quarters);
            mul_b         <= BW'(k_quarters) << (BW - KQ_W);
            state         <= ST_KK;
          end
        end
        ST_KK: begin
          if (mul_sts.done) begin
            mul_ctl.start <= 1'b1;
            mul_ctl.nbits <= MUL_CNT_W'(2 * KQ_W);
            mul_a         <= AW'(spread);
            mul_b         <= BW'(mul_prod[2*KQ_W-1:0]) << (BW - 2 * KQ_W);
            state         <= ST_KS;
          end
        end
        ST_KS: begin
          if (mul_sts.done) begin
            alert_q <= CW'(lhs) > CW'(mul_prod[RW-1:0]);
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_res) begin
            res_valid <= 1'b1;
            res_alert <= alert_q;
            res_fill  <= FILL_W'(filled);
            slot      <= (slot == SLW'(WINDOW - 1)) ? SLW'(0) : slot + 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // port drive
  assign sample.ready      = (state == ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = res_valid;
  assign result.alert      = res_alert;
  assign result.fill_count = res_fill;

  // multiplier is quiet whenever a new reading can be taken
  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mul_sts.busy)
    else $error("multiplier busy while idle");

  // ring pointers stay in range
  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    (filled <= NW'(WINDOW)) && (slot <= SLW'(WINDOW - 1)))
    else $error("fill count or write slot out of range");

  // an input transfer starts the sum update
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_SUM))
    else $error("input transfer did not start processing");

  // finishing loads the output register and frees the input
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    load_res |=> (res_valid && (state == ST_IDLE)))
    else $error("result not loaded on completion");

endmodule
